[rtl/sfp_pkg.sv]
// Shared types and constants for the star field particle step block.
`default_nettype none

package sfp_pkg;

   // Table geometry.
   localparam int STAR_COUNT_DEFAULT = 64;
   localparam int INDEX_W            = 6;
   localparam int INDEX_EXT_W        = 9;

   // Field widths.
   localparam int POS_X_W  = 11;
   localparam int POS_Y_W  = 9;
   localparam int SPEED_W  = 5;
   localparam int ADDR_W   = 11;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int SEED_W   = 16;

   // Random number generator.
   localparam logic [SEED_W-1:0] LCG_MUL        = 16'd13709;
   localparam logic [SEED_W-1:0] LCG_ADD        = 16'd13849;
   localparam logic [SEED_W-1:0] LCG_SEED_RESET = 16'd4;

   // Spawn area and screen bounds, in text cells.
   localparam logic [COL_W-1:0]  SPAWN_COL_BASE = 7'd35;
   localparam logic [ROW_W-1:0]  SPAWN_ROW_BASE = 5'd8;
   localparam logic [COL_W-1:0]  COL_MIN        = 7'd1;
   localparam logic [COL_W-1:0]  COL_MAX        = 7'd78;
   localparam logic [ROW_W-1:0]  ROW_MIN        = 5'd1;
   localparam logic [ROW_W-1:0]  ROW_MAX        = 5'd23;
   localparam logic [ADDR_W-1:0] SCREEN_COLS    = 11'd80;

   // Order of the six draws made when a star is respawned.
   localparam logic [2:0] DRAW_POS_X   = 3'd0;
   localparam logic [2:0] DRAW_POS_Y   = 3'd1;
   localparam logic [2:0] DRAW_SPEED_X = 3'd2;
   localparam logic [2:0] DRAW_SPEED_Y = 3'd3;
   localparam logic [2:0] DRAW_DIR_X   = 3'd4;
   localparam logic [2:0] DRAW_DIR_Y   = 3'd5;

   // One star table entry; a pos_x of zero marks a dead star.
   typedef struct packed {
      logic [POS_X_W-1:0] pos_x;
      logic [POS_Y_W-1:0] pos_y;
      logic [SPEED_W-1:0] speed_x;
      logic [SPEED_W-1:0] speed_y;
      logic               dir_x;
      logic               dir_y;
   } star_entry_type;

endpackage

`default_nettype wire

[rtl/star_field_particle_step.sv]
// Top level: star table sequencer that moves, kills and respawns stars.
// Each request reads its star entry and moves it, or respawns a dead star
// with six draws, one a cycle, on the one generator multiplier; the entry
// is then border-checked and written back. An out-of-range index skips to
// the response. Requests are taken only in idle, after the last response.
// Synchronous reset marks every star dead (valid bits) and seeds the
// generator with four; no clearing pass is needed.
`default_nettype none

module star_field_particle_step #(
   parameter int STAR_COUNT = sfp_pkg::STAR_COUNT_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [sfp_pkg::INDEX_W-1:0]       req_star_index,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_draw_valid,
   output logic [sfp_pkg::ADDR_W-1:0]        rsp_draw_address,
   output logic                              rsp_spawned
);

   localparam int AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MOVE = 5'b00010,
      S_DRAW = 5'b00100,
      S_FIN  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic                              accept;
   logic [sfp_pkg::INDEX_EXT_W-1:0]   index_ext;
   logic                              in_range;
   logic [AW-1:0]                     index_ff;
   logic                              in_range_ff;

   sfp_pkg::star_entry_type           rd_data;
   sfp_pkg::star_entry_type           wr_data;
   logic                              wr_en;

   logic                              lcg_step;
   logic [sfp_pkg::SEED_W-1:0]        draw;
   logic [2:0]                        draw_cnt_ff;

   // Working copy of the star being updated.
   logic [sfp_pkg::POS_X_W-1:0]       work_x_ff;
   logic [sfp_pkg::POS_Y_W-1:0]       work_y_ff;
   logic [sfp_pkg::SPEED_W-1:0]       work_sx_ff;
   logic [sfp_pkg::SPEED_W-1:0]       work_sy_ff;
   logic                              work_dx_ff;
   logic                              work_dy_ff;
   logic                              spawn_ff;

   // Pending response word.
   logic                              pend_valid_ff;
   logic [sfp_pkg::ADDR_W-1:0]        pend_addr_ff;
   logic                              pend_spawn_ff;

   logic                              rsp_valid_ff;
   logic                              rsp_draw_valid_ff;
   logic [sfp_pkg::ADDR_W-1:0]        rsp_draw_address_ff;
   logic                              rsp_spawned_ff;

   logic [sfp_pkg::POS_X_W-1:0]       speed_x_ext;
   logic [sfp_pkg::POS_Y_W-1:0]       speed_y_ext;
   logic [sfp_pkg::POS_X_W-1:0]       moved_x;
   logic [sfp_pkg::POS_Y_W-1:0]       moved_y;
   logic                              is_dead;

   logic [sfp_pkg::COL_W-1:0]         col;
   logic [sfp_pkg::ROW_W-1:0]         row;
   logic                              kill;
   logic [sfp_pkg::ADDR_W-1:0]        cell_addr;
   logic                              out_load;

   // Request handshake and range check.
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign index_ext = {{(sfp_pkg::INDEX_EXT_W - sfp_pkg::INDEX_W){1'b0}}, req_star_index};
   assign in_range  = index_ext < sfp_pkg::INDEX_EXT_W'(STAR_COUNT);

   sfp_star_mem #(
      .DEPTH (STAR_COUNT),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && in_range),
      .rd_addr (index_ext[AW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (index_ff),
      .wr_data (wr_data)
   );

   sfp_lcg u_lcg (
      .clock (clock),
      .reset (reset),
      .step  (lcg_step),
      .draw  (draw)
   );

   // Move one axis: add with wraparound, or subtract saturating at zero.
   assign speed_x_ext = {{(sfp_pkg::POS_X_W - sfp_pkg::SPEED_W){1'b0}}, rd_data.speed_x};
   assign speed_y_ext = {{(sfp_pkg::POS_Y_W - sfp_pkg::SPEED_W){1'b0}}, rd_data.speed_y};

   always_comb begin
      if (!rd_data.dir_x) begin
         moved_x = rd_data.pos_x + speed_x_ext;
      end else if (rd_data.pos_x > speed_x_ext) begin
         moved_x = rd_data.pos_x - speed_x_ext;
      end else begin
         moved_x = '0;
      end
      if (!rd_data.dir_y) begin
         moved_y = rd_data.pos_y + speed_y_ext;
      end else if (rd_data.pos_y > speed_y_ext) begin
         moved_y = rd_data.pos_y - speed_y_ext;
      end else begin
         moved_y = '0;
      end
   end

   assign is_dead = (rd_data.pos_x == '0);

   // Border check and screen cell address on the updated position.
   assign col       = work_x_ff[sfp_pkg::POS_X_W-1:4];
   assign row       = work_y_ff[sfp_pkg::POS_Y_W-1:4];
   assign kill      = (col <= sfp_pkg::COL_MIN) || (col >= sfp_pkg::COL_MAX) ||
                      (row <= sfp_pkg::ROW_MIN) || (row >= sfp_pkg::ROW_MAX);
   assign cell_addr = {{(sfp_pkg::ADDR_W - sfp_pkg::COL_W){1'b0}}, col} +
                      {{(sfp_pkg::ADDR_W - sfp_pkg::ROW_W){1'b0}}, row} * sfp_pkg::SCREEN_COLS;

   // Write back in the final step; a killed star gets a pos_x of zero.
   assign wr_en           = (state_ff == S_FIN);
   assign wr_data.pos_x   = kill ? '0 : work_x_ff;
   assign wr_data.pos_y   = work_y_ff;
   assign wr_data.speed_x = work_sx_ff;
   assign wr_data.speed_y = work_sy_ff;
   assign wr_data.dir_x   = work_dx_ff;
   assign wr_data.dir_y   = work_dy_ff;

   assign lcg_step = (state_ff == S_DRAW);
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            if (!in_range_ff) begin
               state_in = S_OUT;
            end else if (is_dead) begin
               state_in = S_DRAW;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DRAW: begin
            if (draw_cnt_ff == sfp_pkg::DRAW_DIR_Y) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         draw_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_MOVE) begin
            draw_cnt_ff <= '0;
         end else if (lcg_step) begin
            draw_cnt_ff <= draw_cnt_ff + 3'd1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Captured request.
   always_ff @(posedge clock) begin
      if (accept) begin
         index_ff    <= index_ext[AW-1:0];
         in_range_ff <= in_range;
      end
   end

   // Working star: loaded from the moved entry or built one draw a cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_MOVE) begin
         work_x_ff  <= moved_x;
         work_y_ff  <= moved_y;
         work_sx_ff <= rd_data.speed_x;
         work_sy_ff <= rd_data.speed_y;
         work_dx_ff <= rd_data.dir_x;
         work_dy_ff <= rd_data.dir_y;
         spawn_ff   <= is_dead;
      end else if (lcg_step) begin
         case (draw_cnt_ff)
            sfp_pkg::DRAW_POS_X: begin
               work_x_ff <= {sfp_pkg::SPAWN_COL_BASE + {4'd0, draw[3:1]}, 4'd0};
            end
            sfp_pkg::DRAW_POS_Y: begin
               work_y_ff <= {sfp_pkg::SPAWN_ROW_BASE + {2'd0, draw[9:7]}, 4'd0};
            end
            sfp_pkg::DRAW_SPEED_X: begin
               work_sx_ff <= {1'b0, draw[8:5]} + 5'd1;
            end
            sfp_pkg::DRAW_SPEED_Y: begin
               work_sy_ff <= {1'b0, draw[10:7]} + 5'd1;
            end
            sfp_pkg::DRAW_DIR_X: begin
               work_dx_ff <= draw[7];
            end
            sfp_pkg::DRAW_DIR_Y: begin
               work_dy_ff <= draw[3];
            end
            default: begin
            end
         endcase
      end
   end

   // Pending response word; an out-of-range index gives all zeros.
   always_ff @(posedge clock) begin
      if ((state_ff == S_MOVE) && !in_range_ff) begin
         pend_valid_ff <= 1'b0;
         pend_addr_ff  <= '0;
         pend_spawn_ff <= 1'b0;
      end else if (state_ff == S_FIN) begin
         pend_valid_ff <= !kill;
         pend_addr_ff  <= kill ? '0 : cell_addr;
         pend_spawn_ff <= spawn_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_draw_valid_ff   <= pend_valid_ff;
         rsp_draw_address_ff <= pend_addr_ff;
         rsp_spawned_ff      <= pend_spawn_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_draw_valid   = rsp_draw_valid_ff;
   assign rsp_draw_address = rsp_draw_address_ff;
   assign rsp_spawned      = rsp_spawned_ff;

endmodule

`default_nettype wire

[rtl/sfp_star_mem.sv]
// Star table memory with per-entry valid bits cleared at reset.
`default_nettype none

module sfp_star_mem #(
   parameter int DEPTH = sfp_pkg::STAR_COUNT_DEFAULT,
   parameter int AW    = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          rd_en,
   input  wire  [AW-1:0]                rd_addr,
   output sfp_pkg::star_entry_type      rd_data,
   input  wire                          wr_en,
   input  wire  [AW-1:0]                wr_addr,
   input  sfp_pkg::star_entry_type      wr_data
);

   sfp_pkg::star_entry_type star_mem_ff [DEPTH];
   logic [DEPTH-1:0]        entry_valid_ff;
   sfp_pkg::star_entry_type rdata_ff;
   logic                    rvalid_ff;

   // Storage array and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         star_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= star_mem_ff[rd_addr];
      end
   end

   // Valid bits: an entry never written reads as an all-zero (dead) star.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rvalid_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= entry_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

[rtl/sfp_lcg.sv]
// Sixteen-bit linear congruential generator used for respawn draws.
`default_nettype none

module sfp_lcg (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         step,
   output logic [sfp_pkg::SEED_W-1:0]  draw
);

   logic [sfp_pkg::SEED_W-1:0]   seed_ff;
   logic [2*sfp_pkg::SEED_W-1:0] product;

   // The next seed is the draw; only the low half of the product matters.
   assign product = seed_ff * {{sfp_pkg::SEED_W{1'b0}}, sfp_pkg::LCG_MUL};
   assign draw    = product[sfp_pkg::SEED_W-1:0] + sfp_pkg::LCG_ADD;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= sfp_pkg::LCG_SEED_RESET;
      end else if (step) begin
         seed_ff <= draw;
      end
   end

endmodule

`default_nettype wire
